/* rtl/decision_split_evaluator_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decision split evaluator
// Shared property forms, all clocked on the rising edge and idle in reset.
// ----------------------------------------------------------------------------
`ifndef DECISION_SPLIT_EVALUATOR_CORE_ASSERT_SVH
`define DECISION_SPLIT_EVALUATOR_CORE_ASSERT_SVH

// Same-cycle implication
`define DSE_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// Next-cycle implication
`define DSE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

/* rtl/dse_pkg.sv */
// ----------------------------------------------------------------------------
// dse_pkg
// Shared types, constants and arithmetic helpers of the split evaluator.
// ----------------------------------------------------------------------------
package dse_pkg;

    localparam int FEATURE_COUNT  = 16;
    localparam int CATEGORY_COUNT = 64;
    localparam int IDX_W          = 4;
    localparam int CAT_W          = 6;
    localparam int VAL_W          = 32;
    localparam int SUM_W          = 64;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    // Condition kinds
    localparam logic [1:0] KIND_OBLIQUE = 2'd0;
    localparam logic [1:0] KIND_CROSS   = 2'd1;
    localparam logic [1:0] KIND_NOMINAL = 2'd2;

    // Comparison codes
    localparam logic [1:0] CMP_GE = 2'd0;
    localparam logic [1:0] CMP_GT = 2'd1;
    localparam logic [1:0] CMP_LE = 2'd2;
    localparam logic [1:0] CMP_LT = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_KIND       = 3'd0;
    localparam logic [2:0] REG_CMP_FIRST  = 3'd1;
    localparam logic [2:0] REG_CMP_SECOND = 3'd2;
    localparam logic [2:0] REG_FEAT_FIRST = 3'd3;
    localparam logic [2:0] REG_FEAT_SECOND= 3'd4;
    localparam logic [2:0] REG_THR_FIRST  = 3'd5;
    localparam logic [2:0] REG_THR_SECOND = 3'd6;
    localparam logic [2:0] REG_MASK       = 3'd7;

    typedef enum logic {
        OP_WEIGHT  = 1'b0,
        OP_ELEMENT = 1'b1
    } op_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [1:0]              cmp_first;
        logic [1:0]              cmp_second;
        logic [IDX_W-1:0]        feat_first;
        logic [IDX_W-1:0]        feat_second;
        logic signed [VAL_W-1:0] thr_first;
        logic signed [VAL_W-1:0] thr_second;
        logic [CATEGORY_COUNT-1:0] mask;
    } cfg_t;

    // Classified item handed from front to back
    typedef struct packed {
        op_t                     op;
        logic [IDX_W-1:0]        index;
        logic                    in_range;
        logic                    match_first;
        logic                    match_second;
        logic signed [VAL_W-1:0] value;
        logic [CAT_W-1:0]        category;
        logic                    last;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic cmp_val(input logic signed [VAL_W-1:0] v,
                                     input logic signed [VAL_W-1:0] t,
                                     input logic [1:0] op);
        logic r;
        case (op)
            CMP_GE:  r = (v >= t);
            CMP_GT:  r = (v > t);
            CMP_LE:  r = (v <= t);
            default: r = (v < t);
        endcase
        return r;
    endfunction

    function automatic logic cmp_zero(input logic signed [SUM_W-1:0] s,
                                      input logic [1:0] op);
        logic zero;
        logic r;
        zero = (s == '0);
        case (op)
            CMP_GE:  r = !s[SUM_W-1];
            CMP_GT:  r = !s[SUM_W-1] && !zero;
            CMP_LE:  r = s[SUM_W-1] || zero;
            default: r = s[SUM_W-1];
        endcase
        return r;
    endfunction

    // Signed add, clamped to the 64-bit range
    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [SUM_W-1:0] b);
        logic signed [SUM_W:0]   wide;
        logic signed [SUM_W-1:0] r;
        wide = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (wide[SUM_W] != wide[SUM_W-1])
            r = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            r = wide[SUM_W-1:0];
        return r;
    endfunction

    // Q16.16 bias widened to Q32.32 and negated (always fits)
    function automatic logic signed [SUM_W-1:0] neg_bias(input logic signed [VAL_W-1:0] t);
        logic signed [SUM_W-1:0] w;
        w = {{16{t[VAL_W-1]}}, t, 16'h0000};
        return -w;
    endfunction

endpackage

/* rtl/decision_split_evaluator_core.sv */
// ----------------------------------------------------------------------------
// decision_split_evaluator_core
// Evaluates one decision-tree split over a streamed feature vector.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_*      | in        | weight load (tuser 0) or feature element (tuser 1)
//  m_*      | out       | one decision per vector
//  cfg_*    | in        | register writes, no read-back
//
//  One item per cycle is taken while the queue has room; the weight table and
//  multiply-accumulate pipeline handle one element each cycle while m_tready
//  does not stall them. A closing element passes the front register, queue,
//  weight fetch, multiplier, accumulator and bias/compare before m_tvalid rises.
//  Reset clears all control and tracking state; weights are undefined until
//  loaded. A stalled m_tready freezes the back pipeline; the front register
//  and a four-item queue keep taking input meanwhile.
// ----------------------------------------------------------------------------
`include "decision_split_evaluator_core_assert.svh"

module decision_split_evaluator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [3:0] element_index, [35:4] feature_value,
                                   // [41:36] category, rest zero
    input  logic        s_tuser,   // [0] func
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] decision, rest zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    dse_pkg::cfg_t    cfg_reg;
    dse_pkg::q_stat_t q_stat;
    dse_pkg::item_t   push_item;
    dse_pkg::item_t   head;
    logic             push;
    logic             pop;
    logic             decision;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dse_pkg::REG_KIND:        cfg_reg.kind        <= cfg_data[1:0];
                dse_pkg::REG_CMP_FIRST:   cfg_reg.cmp_first   <= cfg_data[1:0];
                dse_pkg::REG_CMP_SECOND:  cfg_reg.cmp_second  <= cfg_data[1:0];
                dse_pkg::REG_FEAT_FIRST:  cfg_reg.feat_first  <= cfg_data[3:0];
                dse_pkg::REG_FEAT_SECOND: cfg_reg.feat_second <= cfg_data[3:0];
                dse_pkg::REG_THR_FIRST:   cfg_reg.thr_first   <= cfg_data[31:0];
                dse_pkg::REG_THR_SECOND:  cfg_reg.thr_second  <= cfg_data[31:0];
                dse_pkg::REG_MASK:        cfg_reg.mask        <= cfg_data;
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    dse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_index    (s_tdata[3:0]),
        .in_value    (s_tdata[35:4]),
        .in_category (s_tdata[41:36]),
        .in_func     (s_tuser),
        .in_last     (s_tlast),
        .cfg         (cfg_reg),
        .q_stat      (q_stat),
        .push        (push),
        .push_item   (push_item)
    );

    dse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    dse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_stat       (q_stat),
        .head         (head),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_decision (decision)
    );

    assign m_tdata = {7'b0, decision};

    // Queue bookkeeping and front backpressure
    `DSE_ASSERT_NOW(a_pop_not_empty, clk, rst_n, pop, !q_stat.empty)
    `DSE_ASSERT_NOW(a_push_not_full, clk, rst_n, push, !q_stat.full)
    `DSE_ASSERT_NEXT(a_push_fills, clk, rst_n, push, !q_stat.empty)
    `DSE_ASSERT_NOW(a_stall_holds_item, clk, rst_n, !s_tready, q_stat.full)

endmodule

/* rtl/dse_front.sv */
// ----------------------------------------------------------------------------
// dse_front
// Accepts input items, classifies them and offers them to the queue.
// ----------------------------------------------------------------------------
module dse_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dse_pkg::IDX_W-1:0]     in_index,
    input  logic signed [dse_pkg::VAL_W-1:0] in_value,
    input  logic [dse_pkg::CAT_W-1:0]     in_category,
    input  logic                          in_func,
    input  logic                          in_last,
    input  dse_pkg::cfg_t                 cfg,
    input  dse_pkg::q_stat_t              q_stat,
    output logic                          push,
    output dse_pkg::item_t                push_item
);

    logic           valid_reg;
    dse_pkg::item_t item_reg;
    dse_pkg::item_t item_next;
    logic           accept;

    assign push     = valid_reg && !q_stat.full;
    assign s_tready = !valid_reg || !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign push_item = item_reg;

    // Classify the incoming item
    always_comb
    begin
        item_next.op           = in_func ? dse_pkg::OP_ELEMENT : dse_pkg::OP_WEIGHT;
        item_next.index        = in_index;
        item_next.in_range     = (int'(in_index) < dse_pkg::FEATURE_COUNT);
        item_next.match_first  = (in_index == cfg.feat_first);
        item_next.match_second = (in_index == cfg.feat_second);
        item_next.value        = in_value;
        item_next.category     = in_category;
        item_next.last         = in_last;
    end

    // Hold the item until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (push)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

/* rtl/dse_queue.sv */
// ----------------------------------------------------------------------------
// dse_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module dse_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dse_pkg::item_t    push_item,
    input  logic              pop,
    output dse_pkg::item_t    head,
    output dse_pkg::q_stat_t  stat
);

    dse_pkg::item_t                slot_reg [dse_pkg::QUEUE_DEPTH];
    logic [dse_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [dse_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [dse_pkg::QCNT_W-1:0]    count_reg;
    logic [dse_pkg::QCNT_W-1:0]    count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == dse_pkg::QCNT_W'(dse_pkg::QUEUE_DEPTH));
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= dse_pkg::QPTR_W'((int'(wr_ptr_reg) + 1) % dse_pkg::QUEUE_DEPTH);
            if (pop)
                rd_ptr_reg <= dse_pkg::QPTR_W'((int'(rd_ptr_reg) + 1) % dse_pkg::QUEUE_DEPTH);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* rtl/dse_back.sv */
// ----------------------------------------------------------------------------
// dse_back
// Weight table, per-element tracking, multiply-accumulate and final decision.
// ----------------------------------------------------------------------------
module dse_back (
    input  logic             clk,
    input  logic             rst_n,
    input  dse_pkg::cfg_t    cfg,
    input  dse_pkg::q_stat_t q_stat,
    input  dse_pkg::item_t   head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_decision
);

    logic                                   adv;
    logic                                   take;
    logic                                   is_elem;
    logic                                   use_elem;

    logic signed [dse_pkg::VAL_W-1:0]       weight_mem [dse_pkg::FEATURE_COUNT];

    // Tracking state of the current vector
    logic                                   first_hit_reg;
    logic                                   second_hit_reg;
    logic [dse_pkg::CAT_W-1:0]              category_reg;
    logic                                   hit1_now;
    logic                                   hit2_now;
    logic                                   hit1_final;
    logic                                   hit2_final;
    logic [dse_pkg::CAT_W-1:0]              cat_final;
    logic                                   aux_next;

    // Multiply stage
    logic                                   s2_valid_reg;
    logic                                   s2_last_reg;
    logic                                   s2_aux_reg;
    logic signed [dse_pkg::VAL_W-1:0]       s2_weight_reg;
    logic signed [dse_pkg::VAL_W-1:0]       s2_value_reg;

    // Accumulate stage
    logic                                   s3_valid_reg;
    logic                                   s3_last_reg;
    logic                                   s3_aux_reg;
    logic signed [dse_pkg::SUM_W-1:0]       s3_product_reg;
    logic signed [dse_pkg::SUM_W-1:0]       sum_reg;
    logic signed [dse_pkg::SUM_W-1:0]       sum_next;

    // Decide stage
    logic                                   s4_valid_reg;
    logic                                   s4_aux_reg;
    logic signed [dse_pkg::SUM_W-1:0]       s4_sum_reg;
    logic                                   decision_next;

    logic                                   out_valid_reg;
    logic                                   decision_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign take     = adv && !q_stat.empty;
    assign pop      = take;
    assign is_elem  = (head.op == dse_pkg::OP_ELEMENT);
    assign use_elem = is_elem && head.in_range;

    assign out_valid    = out_valid_reg;
    assign out_decision = decision_reg;

    // Resolve tracking state including the element now entering
    always_comb
    begin
        hit1_now   = dse_pkg::cmp_val(head.value, cfg.thr_first, cfg.cmp_first);
        hit2_now   = dse_pkg::cmp_val(head.value, cfg.thr_second, cfg.cmp_second);
        hit1_final = (use_elem && head.match_first) ? hit1_now : first_hit_reg;
        hit2_final = (use_elem && head.match_second) ? hit2_now : second_hit_reg;
        cat_final  = (use_elem && head.match_first) ? head.category : category_reg;
        case (cfg.kind)
            dse_pkg::KIND_CROSS:
                aux_next = hit1_final && hit2_final;
            dse_pkg::KIND_NOMINAL:
                aux_next = (int'(cat_final) < dse_pkg::CATEGORY_COUNT) && cfg.mask[cat_final];
            default:
                aux_next = 1'b0;
        endcase
    end

    // Store weights
    always_ff @(posedge clk)
    begin
        if (take && !is_elem && head.in_range)
            weight_mem[head.index] <= head.value;
    end

    // Fetch weight and operands for the multiplier
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_weight_reg <= use_elem ? weight_mem[head.index] : '0;
            s2_value_reg  <= head.value;
            s2_last_reg   <= head.last;
            s2_aux_reg    <= aux_next;
        end
    end

    // Track hits and category; clear them at the end of a vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_hit_reg  <= 1'b0;
            second_hit_reg <= 1'b0;
            category_reg   <= '0;
            s2_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= take && is_elem;
            if (take && is_elem)
            begin
                if (head.last)
                begin
                    first_hit_reg  <= 1'b0;
                    second_hit_reg <= 1'b0;
                    category_reg   <= '0;
                end
                else
                begin
                    first_hit_reg  <= hit1_final;
                    second_hit_reg <= hit2_final;
                    category_reg   <= cat_final;
                end
            end
        end
    end

    // Multiply
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_product_reg <= s2_weight_reg * s2_value_reg;
            s3_last_reg    <= s2_last_reg;
            s3_aux_reg     <= s2_aux_reg;
        end
    end

    assign sum_next = dse_pkg::sat_add(sum_reg, s3_product_reg);

    // Accumulate and hand the closed sum on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg && s3_last_reg;
            if (s3_valid_reg)
                sum_reg <= s3_last_reg ? '0 : sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s3_valid_reg && s3_last_reg)
        begin
            s4_sum_reg <= sum_next;
            s4_aux_reg <= s3_aux_reg;
        end
    end

    // Subtract bias and decide (oblique), else pass the tracked result on
    always_comb
    begin
        if (cfg.kind == dse_pkg::KIND_OBLIQUE)
            decision_next = dse_pkg::cmp_zero(
                dse_pkg::sat_add(s4_sum_reg, dse_pkg::neg_bias(cfg.thr_first)), cfg.cmp_first);
        else
            decision_next = s4_aux_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s4_valid_reg)
            decision_reg <= decision_next;
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split evaluator stream testbench
// Loads hyperplane weights and streams feature vectors through the evaluator
// under a series of register settings, predicts each decision in a local
// Q32.32 mirror of the block and compares it with every decision that leaves
// the master port. Both ports idle and stall at random, phase by phase, but not in the last third.
// ----------------------------------------------------------------------------
module tb;
    import dse_pkg::*;

    localparam int         PHASES        = 12;
    localparam int         PHASE_ITEMS   = 125;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         STALL_LIMIT   = 4000;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        op_t                op;
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic [5:0]         cat;
        logic               last;
    } elem_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // [3:0] element_index, [35:4] feature_value,
                                  // [41:36] category, rest zero
    logic        s_tuser = 1'b0;  // [0] func
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [0] decision, rest zero
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    decision_split_evaluator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register mirror
    logic [1:0]         mir_kind;
    logic [1:0]         mir_cmp_first;
    logic [1:0]         mir_cmp_second;
    logic [3:0]         mir_feat_first;
    logic [3:0]         mir_feat_second;
    logic signed [31:0] mir_thr_first;
    logic signed [31:0] mir_thr_second;
    logic [63:0]        mir_mask;

    // Evaluation state mirror
    logic signed [31:0] weight_mirror [FEATURE_COUNT];
    longint             running_dot;
    bit                 first_ok;
    bit                 second_ok;
    logic [5:0]         chosen_cat;

    elem_item_t pending_items[$];
    bit         expected_decisions[$];
    elem_item_t cur_item;

    int items_queued   = 0;
    int items_accepted = 0;
    int decisions_seen = 0;
    int fails          = 0;
    int stall_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit holds(input longint a, input longint b, input logic [1:0] code);
        case (code)
            CMP_GE:  return a >= b;
            CMP_GT:  return a > b;
            CMP_LE:  return a <= b;
            default: return a < b;
        endcase
    endfunction

    // 64-bit add, clamped at both ends
    function automatic longint sat_sum(input longint a, input longint b);
        longint r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return r;
    endfunction

    // Advance the mirror by one accepted item; queue the decision it closes
    task automatic evaluate_split(input elem_item_t it);
        bit     dec;
        longint biased;
        if (it.op == OP_WEIGHT)
        begin
            weight_mirror[it.idx] = it.val;
            return;
        end
        running_dot = sat_sum(running_dot, longint'(weight_mirror[it.idx]) * longint'(it.val));
        if (it.idx == mir_feat_first)
        begin
            first_ok   = holds(it.val, mir_thr_first, mir_cmp_first);
            chosen_cat = it.cat;
        end
        if (it.idx == mir_feat_second)
            second_ok = holds(it.val, mir_thr_second, mir_cmp_second);
        if (!it.last)
            return;
        case (mir_kind)
            KIND_OBLIQUE:
            begin
                biased = sat_sum(running_dot, -(longint'(mir_thr_first) * 64'sd65536));
                dec    = holds(biased, 0, mir_cmp_first);
            end
            KIND_CROSS:   dec = first_ok && second_ok;
            KIND_NOMINAL: dec = mir_mask[chosen_cat];
            default:      dec = 1'b0;
        endcase
        expected_decisions.insert(expected_decisions.size(), dec);
        running_dot = 0;
        first_ok    = 1'b0;
        second_ok   = 1'b0;
        chosen_cat  = '0;
    endtask

    // Driver: hold the item until taken, then fetch the next or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                evaluate_split(cur_item);
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_item.op;
                    s_tdata  <= {6'b0, cur_item.cat, cur_item.val, cur_item.idx};
                    s_tlast  <= cur_item.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each decision against the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                decisions_seen++;
                if (expected_decisions.size() == 0)
                begin
                    $error("decision: none expected, got %0d", m_tdata[0]);
                    fails++;
                end
                else
                begin
                    automatic bit exp_dec = expected_decisions.pop_front();
                    if (m_tdata[0] !== exp_dec)
                    begin
                        $error("decision: expected %0d, got %0d", exp_dec, m_tdata[0]);
                        fails++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic push_item(input op_t op, input logic [3:0] idx,
                             input logic signed [31:0] val, input logic [5:0] cat,
                             input logic last);
        elem_item_t it;
        it.op   = op;
        it.idx  = idx;
        it.val  = val;
        it.cat  = cat;
        it.last = last;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    // Near the given centre, at the extremes or zero, otherwise anything
    function automatic logic signed [31:0] pick_value(input logic signed [31:0] centre);
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 32'sd0;
            3, 4:    return centre + $signed($urandom_range(0, 4)) - 32'sd2;
            default: return $urandom;
        endcase
    endfunction

    // Queue one vector of len elements, drawing no index from the avoid set
    task automatic queue_vector(input int len, input logic [15:0] avoid);
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic [5:0]         cat;
        for (int i = 0; i < len; i++)
        begin
            // stray weight reload inside the vector
            if ($urandom_range(0, 19) == 0)
                push_item(OP_WEIGHT, 4'($urandom_range(0, 15)), pick_value(0),
                          6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            do
                idx = 4'($urandom_range(0, 15));
            while (avoid[idx]);
            if (idx == mir_feat_first && $urandom_range(0, 1))
                val = pick_value(mir_thr_first);
            else if (idx == mir_feat_second && $urandom_range(0, 1))
                val = pick_value(mir_thr_second);
            else
                val = pick_value(0);
            case ($urandom_range(0, 5))
                0:       cat = 6'd0;
                1:       cat = 6'd63;
                default: cat = 6'($urandom_range(0, 63));
            endcase
            push_item(OP_ELEMENT, idx, val, cat, i == len - 1);
        end
    endtask

    // Write one register and keep the mirror in step
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_KIND:        mir_kind        = data[1:0];
            REG_CMP_FIRST:   mir_cmp_first   = data[1:0];
            REG_CMP_SECOND:  mir_cmp_second  = data[1:0];
            REG_FEAT_FIRST:  mir_feat_first  = data[3:0];
            REG_FEAT_SECOND: mir_feat_second = data[3:0];
            REG_THR_FIRST:   mir_thr_first   = data[31:0];
            REG_THR_SECOND:  mir_thr_second  = data[31:0];
            default:         mir_mask        = data;
        endcase
    endtask

    // Pause the sender until every decision is in and the pipeline is empty
    task automatic wait_drained();
        while (!(items_accepted == items_queued && expected_decisions.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] thr_choice(input int sel);
        case (sel % 4)
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int          phase_start;
        int          len;
        logic [1:0]  kind;
        logic [3:0]  feat_first;
        logic [3:0]  feat_second;
        logic [63:0] mask;

        mir_kind        = KIND_OBLIQUE;
        mir_cmp_first   = CMP_GE;
        mir_cmp_second  = CMP_GE;
        mir_feat_first  = '0;
        mir_feat_second = '0;
        mir_thr_first   = '0;
        mir_thr_second  = '0;
        mir_mask        = '0;
        running_dot     = 0;
        first_ok        = 1'b0;
        second_ok       = 1'b0;
        chosen_cat      = '0;

        // Load every weight slot first; a last mark on a weight is ignored
        for (int i = 0; i < FEATURE_COUNT; i++)
            push_item(OP_WEIGHT, 4'(i),
                      (i < 2) ? VAL_MIN : (i == 15) ? VAL_MAX : logic'(0) ? 0 : $urandom,
                      6'($urandom_range(0, 63)), i == 7);
        // Positive saturation of the running sum
        push_item(OP_ELEMENT, 4'd0, VAL_MIN, 6'd63, 1'b0);
        push_item(OP_ELEMENT, 4'd1, VAL_MIN, 6'd0, 1'b0);
        push_item(OP_ELEMENT, 4'd0, VAL_MIN, 6'd21, 1'b0);
        push_item(OP_ELEMENT, 4'd1, VAL_MIN, 6'd42, 1'b1);
        // Single-element vector, then a sum of exactly zero
        push_item(OP_ELEMENT, 4'd15, VAL_MIN, 6'd63, 1'b1);
        push_item(OP_ELEMENT, 4'd2, 32'sd0, 6'd0, 1'b1);
        // Negative saturation of the running sum
        push_item(OP_ELEMENT, 4'd15, VAL_MIN, 6'd1, 1'b0);
        push_item(OP_ELEMENT, 4'd15, VAL_MIN, 6'd2, 1'b0);
        push_item(OP_ELEMENT, 4'd15, VAL_MIN, 6'd3, 1'b1);

        send_idle_pct = 33;
        recv_idle_pct = 67;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            // Idling pattern by third of the run
            if (p < PHASES / 3)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 67;
            end
            else if (p < 2 * PHASES / 3)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Register setting for this phase
            kind = (p == PHASES - 1) ? KIND_UNUSED : 2'(p % 3);
            case ((p / 3) % 3)
                0:       feat_first = 4'd0;
                1:       feat_first = 4'd15;
                default: feat_first = 4'($urandom_range(0, 15));
            endcase
            case (p % 4)
                0:       feat_second = 4'd15;
                1:       feat_second = 4'd0;
                2:       feat_second = feat_first;
                default: feat_second = 4'($urandom_range(0, 15));
            endcase
            case ((p / 3) % 3)
                0:       mask = {$urandom, $urandom};
                1:       mask = '1;
                default: mask = 64'd1 << $urandom_range(0, 63);
            endcase
            if (p == 2)
                mask = '0;
            write_reg(REG_KIND, 64'(kind));
            write_reg(REG_CMP_FIRST, 64'(p % 4));
            write_reg(REG_CMP_SECOND, 64'((p + 1) % 4));
            write_reg(REG_FEAT_FIRST, 64'(feat_first));
            write_reg(REG_FEAT_SECOND, 64'(feat_second));
            write_reg(REG_THR_FIRST, {32'hFFFF_FFFF, thr_choice(p)});
            write_reg(REG_THR_SECOND, {32'h0, thr_choice(p + 2)});
            write_reg(REG_MASK, mask);
            @(posedge clk);
            cfg_we <= 1'b0;

            // Vectors without the first selected feature, then without either one
            queue_vector(4, 16'(1) << feat_first);
            queue_vector(3, (16'(1) << feat_first) | (16'(1) << feat_second));
            // The selected features exactly at their thresholds
            push_item(OP_ELEMENT, feat_second, mir_thr_second, 6'd63, 1'b0);
            push_item(OP_ELEMENT, feat_first, mir_thr_first, 6'($urandom_range(0, 63)), 1'b1);

            // Random vectors, now and then a lone element or a stray weight
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = 1;
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(17, 24);
                else
                    len = $urandom_range(2, 16);
                queue_vector(len, 16'h0000);
            end
            wait_drained();
        end

        $display("Streamed %0d items and checked %0d decisions over %0d register settings,",
                 items_queued, decisions_seen, PHASES + 1);
        $display("covering all condition kinds, comparison codes and saturation at both ends");
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dse_pkg.sv
rtl/dse_front.sv
rtl/dse_queue.sv
rtl/dse_back.sv
rtl/decision_split_evaluator_core.sv
test/tb.sv
